/* design/tea_pkg.sv */
// Shared types, constants and the round function for the TEA cipher unit.
// Used by tea_key_regs, tea_cell and tea_block_cipher_unit; no dependencies.
package tea_pkg;

  localparam int unsigned TeaRounds = 32;
  localparam logic [31:0] TeaDelta  = 32'h9e37_79b9;
  localparam int unsigned CfgIdxW   = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegKeyWord0 = 3'd0,
    RegKeyWord1 = 3'd1,
    RegKeyWord2 = 3'd2,
    RegKeyWord3 = 3'd3,
    RegKeyValid = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic        valid;
  } key_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] block_in;
    logic        last_block;
  } tea_in_t;

  typedef struct packed {
    logic [63:0] block_out;
    logic        status;
    logic        last_out;
  } tea_out_t;

  // What travels from one cell to the next.
  typedef struct packed {
    logic        kind;
    logic [31:0] v0;
    logic [31:0] v1;
    logic        last;
  } stage_t;

  function automatic logic [31:0] tea_mix(input logic [31:0] x,
                                          input logic [31:0] ka,
                                          input logic [31:0] kb,
                                          input logic [31:0] s);
    tea_mix = ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
  endfunction

endpackage

/* design/tea_block_cipher_unit.sv */
// TEA block cipher unit: a chain of 2*ROUNDS half-round cells, one block per transfer.
// Each block passes through the cell registers in chain order; the result strobe comes from
// the valid register of the last cell.
// Throughput is one block every cycle; busy_o is never raised and the receiver cannot stall.
// Reset clears the key registers (key not loaded) and empties the cell chain.
// Depends on tea_pkg, tea_key_regs and tea_cell.
module tea_block_cipher_unit import tea_pkg::*; #(
  parameter int unsigned ROUNDS = TeaRounds
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  tea_in_t            cmd_i,
  output logic               res_valid_o,
  output tea_out_t           result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int unsigned NumCells = 2 * ROUNDS;

  key_t   key;
  logic   accept;
  logic   cell_valid [NumCells+1];
  stage_t cell_stage [NumCells+1];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  tea_key_regs u_key_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .key_o       (key)
  );

  assign cell_valid[0]      = accept;
  assign cell_stage[0].kind = cmd_i.kind;
  assign cell_stage[0].v0   = cmd_i.block_in[31:0];
  assign cell_stage[0].v1   = cmd_i.block_in[63:32];
  assign cell_stage[0].last = cmd_i.last_block;

  for (genvar c = 0; c < NumCells; c++) begin : g_cell
    // Cell pair j computes TEA round j of encryption and undoes round ROUNDS-1-j in decryption.
    localparam logic [31:0] EncSum = 32'(TeaDelta * ((c / 2) + 1));
    localparam logic [31:0] DecSum = 32'(TeaDelta * (ROUNDS - (c / 2)));

    tea_cell #(
      .EncSum     (EncSum),
      .DecSum     (DecSum),
      .SecondHalf (1'((c % 2)))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cell_valid[c]),
      .stage_i (cell_stage[c]),
      .key_i   (key),
      .valid_o (cell_valid[c+1]),
      .stage_o (cell_stage[c+1])
    );
  end

  // Change the key only while the chain is empty (unenforced); it is checked at the far end.
  assign res_valid_o        = cell_valid[NumCells];
  assign result_o.block_out = key.valid ? {cell_stage[NumCells].v1, cell_stage[NumCells].v0}
                                        : 64'd0;
  assign result_o.status    = ~key.valid;
  assign result_o.last_out  = cell_stage[NumCells].last;

  a_res_from_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start_i, NumCells))
    else $error("result strobe without a start 2*ROUNDS cycles earlier");

  a_last_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> result_o.last_out == $past(cmd_i.last_block, NumCells))
    else $error("last-block marker not carried through the cell chain");

  a_error_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && result_o.status) |-> result_o.block_out == 64'd0)
    else $error("error status with a non-zero block");

endmodule

/* design/tea_key_regs.sv */
// Key registers of the TEA cipher unit, written through the configuration channel.
// Depends on tea_pkg for the register codes and the key struct.
module tea_key_regs import tea_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output key_t               key_o
);

  key_t key_q, key_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    key_d = key_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegKeyWord0: key_d.word0 = cfg_data_i;
        RegKeyWord1: key_d.word1 = cfg_data_i;
        RegKeyWord2: key_d.word2 = cfg_data_i;
        RegKeyWord3: key_d.word3 = cfg_data_i;
        RegKeyValid: key_d.valid = cfg_data_i[0];
        default:     key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

/* design/tea_cell.sv */
// One Feistel half-round of TEA, registered; serves encryption and decryption.
// Depends on tea_pkg for the stage struct, the key struct and tea_mix.
module tea_cell import tea_pkg::*; #(
  parameter logic [31:0] EncSum     = TeaDelta,
  parameter logic [31:0] DecSum     = TeaDelta,
  parameter bit          SecondHalf = 1'b0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  stage_t stage_i,
  input  key_t   key_i,
  output logic   valid_o,
  output stage_t stage_o
);

  logic        upd_v0;
  logic [31:0] sum, src, ka, kb, mix, dst, upd;
  logic        valid_q;
  stage_t      stage_q, stage_d;

  // Encryption updates v0 first, decryption runs the halves in reverse and updates v1 first.
  assign upd_v0 = ~(stage_i.kind ^ SecondHalf);
  assign sum    = stage_i.kind ? DecSum : EncSum;
  assign src    = upd_v0 ? stage_i.v1 : stage_i.v0;
  assign dst    = upd_v0 ? stage_i.v0 : stage_i.v1;
  assign ka     = upd_v0 ? key_i.word0 : key_i.word2;
  assign kb     = upd_v0 ? key_i.word1 : key_i.word3;
  assign mix    = tea_mix(src, ka, kb, sum);
  assign upd    = stage_i.kind ? (dst - mix) : (dst + mix);

  always_comb begin
    stage_d = stage_i;
    if (upd_v0) begin
      stage_d.v0 = upd;
    end else begin
      stage_d.v1 = upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule
